// File: sv/mpq_pkg.sv
// package for the min priority queue: payload types, codes and defaults
`default_nettype none

package mpq_pkg;

	// default sizes
	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// action codes
	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_STATUS = 2'd2;

	// error codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	// input transaction
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] push_value;
	} in_t;

	// output transaction
	typedef struct packed {
		logic [31:0] popped_value;
		logic        pop_valid;
		logic [1:0]  error_code;
		logic [4:0]  entry_count;
		logic        is_empty;
	} out_t;

	// shift command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/mpq_cell.sv
// one cell of the sorted shift-register store
`default_nettype none

module mpq_cell import mpq_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cell_ctrl_t             ctrl,
	input  wire logic [VALUE_WIDTH-1:0] push_value,
	input  wire logic [VALUE_WIDTH-1:0] prev_value,
	input  wire logic                   prev_take,
	input  wire logic                   prev_occupied,
	input  wire logic [VALUE_WIDTH-1:0] next_value,
	input  wire logic                   next_occupied,
	output logic [VALUE_WIDTH-1:0]      value,
	output logic                        occupied,
	output logic                        take
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   occupied_q;

	// this cell is at or past the insert point
	assign take     = !occupied_q || (value_q > push_value);
	assign value    = value_q;
	assign occupied = occupied_q;

	// occupancy moves with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= 1'b0;
		end else if (ctrl.push) begin
			if (take) begin
				occupied_q <= prev_occupied;
			end
		end else if (ctrl.pop) begin
			occupied_q <= next_occupied;
		end
	end

	// shift right on insert, left on removal
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (take) begin
				value_q <= prev_take ? prev_value : push_value;
			end
		end else if (ctrl.pop) begin
			value_q <= next_value;
		end
	end

endmodule

`default_nettype wire

// File: sv/min_priority_queue_top.sv
// top level of the min priority queue: cell chain, count and output register
//
// A bounded queue that always hands out its least stored value.
// Input channel (in_valid, in_ready, in_data): each transaction is a push,
// a pop of the least value, or a status query (action code three acts as a
// status query). Output channel (out_valid, out_ready, out_data): exactly
// one result per input transaction, in order, with the popped value, an
// error code, and the count and empty flag after the transaction.
// The store is a row of DEPTH cells kept in ascending order; every cell
// compares against the pushed value in parallel and shifts by one place,
// so the result of a transaction shows in the cycle after acceptance.
// One transaction per cycle is taken while out_ready is high.
// When the receiver stalls, the result waits in the output register and
// in_ready drops until it is taken.
// A push into a full store is dropped with ERR_FULL; a pop on an empty
// store returns zero with ERR_EMPTY.
// Reset empties the queue and the output register at once; no sweep runs.
`default_nettype none

module min_priority_queue_top import mpq_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [VALUE_WIDTH-1:0] push_val;
	logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic                   cell_occ   [DEPTH];
	logic                   cell_take  [DEPTH];
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_next;
	logic                   accept;
	logic                   is_push;
	logic                   is_pop;
	logic                   full;
	logic                   empty;
	cell_ctrl_t             ctrl;
	out_t                   result;
	out_t                   out_q;
	logic                   out_valid_q;

	// handshake
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign push_val = VALUE_WIDTH'(in_data.push_value);
	assign is_push  = (in_data.action == ACT_PUSH);
	assign is_pop   = (in_data.action == ACT_POP);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// command to the cells
	assign ctrl.push = accept && is_push && !full;
	assign ctrl.pop  = accept && is_pop && !empty;

	// cell chain, least value in cell zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] prev_value;
		logic                   prev_take;
		logic                   prev_occupied;
		logic [VALUE_WIDTH-1:0] next_value;
		logic                   next_occupied;

		if (i == 0) begin : g_head
			assign prev_value    = '0;
			assign prev_take     = 1'b0;
			assign prev_occupied = 1'b1;
		end else begin : g_body
			assign prev_value    = cell_value[i-1];
			assign prev_take     = cell_take[i-1];
			assign prev_occupied = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_value    = '0;
			assign next_occupied = 1'b0;
		end else begin : g_link
			assign next_value    = cell_value[i+1];
			assign next_occupied = cell_occ[i+1];
		end

		mpq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.push_value   (push_val),
			.prev_value   (prev_value),
			.prev_take    (prev_take),
			.prev_occupied(prev_occupied),
			.next_value   (next_value),
			.next_occupied(next_occupied),
			.value        (cell_value[i]),
			.occupied     (cell_occ[i]),
			.take         (cell_take[i])
		);
	end

	// count after this transaction
	always_comb begin
		count_next = count_q;
		if (ctrl.push) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// result of the accepted transaction
	always_comb begin
		result              = '0;
		result.entry_count  = 5'(count_next);
		result.is_empty     = (count_next == '0);
		result.error_code   = ERR_OK;
		if (is_push && full) begin
			result.error_code = ERR_FULL;
		end else if (is_pop && empty) begin
			result.error_code = ERR_EMPTY;
		end else if (is_pop) begin
			result.popped_value = 32'(cell_value[0]);
			result.pop_valid    = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire

// File: sim/tb_min_priority_queue_top.sv
// testbench for min_priority_queue_top: directed table, random push/pop mix, ordered-store predictor
`timescale 1ns / 100ps
`default_nettype none

module tb_min_priority_queue_top;
	import mpq_pkg::*;

	localparam int Q_DEPTH = DEPTH_DEF;
	// unused action code, behaves as a status query
	localparam logic [1:0] ACT_SPARE = 2'd3;
	// slots in the expected-result ring and rows in the directed table
	localparam int PEND_SLOTS = 64;
	localparam int PLAN_ROWS  = 32;

	// one row of the directed table
	typedef struct {
		in_t  txn;
		bit   typed;
		out_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// predictor state: ascending store and count
	logic [31:0] sorted_vals [Q_DEPTH];
	int          held;

	// expected results in flight, written at pend_wr and read at pend_rd
	out_t      pend_buf [PEND_SLOTS];
	int        pend_wr;
	int        pend_rd;
	plan_row_t plan [PLAN_ROWS];
	int        n_plan;
	int        mismatches;
	int        checked;
	int        n_push;
	int        n_popped;
	int        n_full;
	int        n_empty;
	bit        calm;

	min_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// expected result of one transaction, updates the predictor state
	function automatic out_t predict_queue_step(in_t txn);
		out_t r;
		int   pos;
		r = '0;
		case (txn.action)
			ACT_PUSH: begin
				if (held >= Q_DEPTH) begin
					r.error_code = ERR_FULL;
				end else begin
					pos = held;
					while (pos > 0 && sorted_vals[pos - 1] > txn.push_value) begin
						sorted_vals[pos] = sorted_vals[pos - 1];
						pos--;
					end
					sorted_vals[pos] = txn.push_value;
					held++;
				end
			end
			ACT_POP: begin
				if (held == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					r.popped_value = sorted_vals[0];
					r.pop_valid    = 1'b1;
					for (int i = 1; i < held; i++)
						sorted_vals[i - 1] = sorted_vals[i];
					held--;
				end
			end
			default: ;
		endcase
		r.entry_count = 5'(held);
		r.is_empty    = (held == 0);
		return r;
	endfunction

	function automatic out_t result_of(logic [31:0] val, logic valid, logic [1:0] err,
			logic [4:0] cnt, logic empty);
		out_t r;
		r.popped_value = val;
		r.pop_valid    = valid;
		r.error_code   = err;
		r.entry_count  = cnt;
		r.is_empty     = empty;
		return r;
	endfunction

	function automatic plan_row_t plan_row(logic [1:0] act, logic [31:0] val, bit typed,
			out_t want);
		plan_row_t p;
		p.txn.action     = act;
		p.txn.push_value = val;
		p.typed          = typed;
		p.want           = want;
		return p;
	endfunction

	// append one row to the directed table
	function automatic void add_plan(plan_row_t p);
		plan[n_plan] = p;
		n_plan++;
	endfunction

	function automatic in_t random_txn(int push_pct);
		in_t t;
		int  r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			t.action = ACT_PUSH;
		else if (r < 96)
			t.action = ACT_POP;
		else if (r < 98)
			t.action = ACT_STATUS;
		else
			t.action = ACT_SPARE;
		case ($urandom_range(0, 3))
			0: t.push_value = $urandom_range(0, 7);
			1: case ($urandom_range(0, 3))
				0: t.push_value = 32'h0000_0000;
				1: t.push_value = 32'hFFFF_FFFF;
				2: t.push_value = 32'h8000_0000;
				default: t.push_value = 32'h7FFF_FFFF;
			endcase
			default: t.push_value = $urandom;
		endcase
		return t;
	endfunction

	// drive one transaction, entered and left just after a falling edge
	task automatic send_txn(input in_t txn, input bit typed, input out_t want);
		int   gap;
		out_t predicted;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= txn;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_queue_step(txn);
		pend_buf[pend_wr % PEND_SLOTS] = typed ? want : predicted;
		pend_wr++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pend_wr != pend_rd) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pend_wr == pend_rd) begin
				note_mismatch("unexpected result, popped_value", 32'h0, out_data.popped_value);
			end else begin
				want = pend_buf[pend_rd % PEND_SLOTS];
				pend_rd++;
				checked++;
				if (out_data.popped_value !== want.popped_value)
					note_mismatch("popped_value", want.popped_value, out_data.popped_value);
				if (out_data.pop_valid !== want.pop_valid)
					note_mismatch("pop_valid", 32'(want.pop_valid), 32'(out_data.pop_valid));
				if (out_data.error_code !== want.error_code)
					note_mismatch("error_code", 32'(want.error_code), 32'(out_data.error_code));
				if (out_data.entry_count !== want.entry_count)
					note_mismatch("entry_count", 32'(want.entry_count),
						32'(out_data.entry_count));
				if (out_data.is_empty !== want.is_empty)
					note_mismatch("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
				if (want.pop_valid)
					n_popped++;
				if (want.error_code == ERR_FULL)
					n_full++;
				if (want.error_code == ERR_EMPTY)
					n_empty++;
			end
		end
	end

	// receiver: random stall before each result
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		logic [31:0] fill_vals [16];
		int          push_pct;
		in_t         txn;
		fill_vals = '{32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'h5, 32'h5, 32'hFFFF_FFFF,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h3, 32'h3, 32'h1234_5678,
			32'hFFFF_FFFE, 32'h2, 32'h0000_0100, 32'h9};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		held       = 0;
		pend_wr    = 0;
		pend_rd    = 0;
		n_plan     = 0;
		mismatches = 0;
		checked    = 0;
		n_push     = 0;
		n_popped   = 0;
		n_full     = 0;
		n_empty    = 0;
		calm       = 1'b0;
		for (int i = 0; i < Q_DEPTH; i++)
			sorted_vals[i] = '0;

		// directed table: empty cases, extremes, spare code, fill to full
		add_plan(plan_row(ACT_STATUS, 32'h0, 1'b1,
			result_of(32'h0, 1'b0, ERR_OK, 5'd0, 1'b1)));
		add_plan(plan_row(ACT_POP, 32'h0, 1'b1,
			result_of(32'h0, 1'b0, ERR_EMPTY, 5'd0, 1'b1)));
		add_plan(plan_row(ACT_SPARE, 32'hFFFF_FFFF, 1'b1,
			result_of(32'h0, 1'b0, ERR_OK, 5'd0, 1'b1)));
		add_plan(plan_row(ACT_PUSH, 32'hFFFF_FFFF, 1'b1,
			result_of(32'h0, 1'b0, ERR_OK, 5'd1, 1'b0)));
		add_plan(plan_row(ACT_PUSH, 32'h0, 1'b1,
			result_of(32'h0, 1'b0, ERR_OK, 5'd2, 1'b0)));
		add_plan(plan_row(ACT_POP, 32'h0, 1'b1,
			result_of(32'h0, 1'b1, ERR_OK, 5'd1, 1'b0)));
		add_plan(plan_row(ACT_POP, 32'h0, 1'b1,
			result_of(32'hFFFF_FFFF, 1'b1, ERR_OK, 5'd0, 1'b1)));
		add_plan(plan_row(ACT_POP, 32'h0, 1'b1,
			result_of(32'h0, 1'b0, ERR_EMPTY, 5'd0, 1'b1)));
		for (int i = 0; i < 16; i++)
			add_plan(plan_row(ACT_PUSH, fill_vals[i], 1'b0, '0));
		add_plan(plan_row(ACT_PUSH, 32'h2A, 1'b1,
			result_of(32'h0, 1'b0, ERR_FULL, 5'd16, 1'b0)));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < n_plan; i++) begin
			if (plan[i].txn.action == ACT_PUSH)
				n_push++;
			send_txn(plan[i].txn, plan[i].typed, plan[i].want);
		end
		in_valid <= 1'b0;
		wait_drained();

		// random part: fill-heavy, drain-heavy and balanced phases
		for (int n = 0; n < 500; n++) begin
			if (n % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			case ((n / 50) % 4)
				0: push_pct = 75;
				1: push_pct = 25;
				default: push_pct = 50;
			endcase
			if (n == 250) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			txn = random_txn(push_pct);
			if (txn.action == ACT_PUSH)
				n_push++;
			send_txn(txn, 1'b0, '0);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		while (pend_wr != pend_rd) @(posedge clk);
		repeat (4) @(posedge clk);
		if (pend_wr != pend_rd)
			mismatches++;

		$display("checked %0d results: %0d pushes, %0d values popped", checked, n_push,
			n_popped);
		$display("full-store drops %0d, pops on empty %0d", n_full, n_empty);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
